@@ src/led_fx_pkg.sv @@
// Shared types, constants, microcode ROM and color wheel for the LED frame engine.
`timescale 1ns / 1ps

package led_fx_pkg;

    // Strip geometry
    localparam int NUM_PIXELS  = 3;
    localparam int FRAME_BYTES = NUM_PIXELS * 3;
    localparam int PIX_W       = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    // Input and output transactions
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] flash_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic [5:0] byte_position;
        logic       last;
    } t_out_item;

    // Datapath operations
    typedef logic [2:0] t_op;
    localparam t_op OP_IDLE  = 3'd0;
    localparam t_op OP_START = 3'd1;
    localparam t_op OP_SCALE = 3'd2;
    localparam t_op OP_MOD   = 3'd3;
    localparam t_op OP_COLOR = 3'd4;
    localparam t_op OP_MUL   = 3'd5;
    localparam t_op OP_EMIT  = 3'd6;
    localparam t_op OP_NOP   = 3'd7;

    // Jump conditions
    typedef logic [2:0] t_cond;
    localparam t_cond C_NEXT    = 3'd0;
    localparam t_cond C_ALWAYS  = 3'd1;
    localparam t_cond C_NOTICK  = 3'd2;
    localparam t_cond C_NOFRAME = 3'd3;
    localparam t_cond C_QGE     = 3'd4;
    localparam t_cond C_BUSY    = 3'd5;
    localparam t_cond C_FEND    = 3'd6;
    localparam t_cond C_INPIX   = 3'd7;

    // Program addresses
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;
    localparam t_pc S_IDLE  = 4'd0;
    localparam t_pc S_TICK  = 4'd1;
    localparam t_pc S_SCALE = 4'd2;
    localparam t_pc S_MOD   = 4'd3;
    localparam t_pc S_COLOR = 4'd4;
    localparam t_pc S_MUL   = 4'd5;
    localparam t_pc S_EMIT  = 4'd6;
    localparam t_pc S_FEND  = 4'd7;
    localparam t_pc S_PIX   = 4'd8;
    localparam t_pc S_NEXTP = 4'd9;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic tick;
        logic no_frame;
        logic q_ge;
        logic out_busy;
        logic frame_end;
        logic in_pixel;
    } t_status;

    // Control program: jump to target when the condition holds, else step on
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            S_IDLE:  w = '{OP_IDLE,  C_NOTICK,  S_IDLE};
            S_TICK:  w = '{OP_START, C_NOFRAME, S_IDLE};
            S_SCALE: w = '{OP_SCALE, C_NEXT,    S_IDLE};
            S_MOD:   w = '{OP_MOD,   C_QGE,     S_MOD};
            S_COLOR: w = '{OP_COLOR, C_NEXT,    S_IDLE};
            S_MUL:   w = '{OP_MUL,   C_NEXT,    S_IDLE};
            S_EMIT:  w = '{OP_EMIT,  C_BUSY,    S_EMIT};
            S_FEND:  w = '{OP_NOP,   C_FEND,    S_IDLE};
            S_PIX:   w = '{OP_NOP,   C_INPIX,   S_MUL};
            S_NEXTP: w = '{OP_NOP,   C_ALWAYS,  S_COLOR};
            default: w = '{OP_NOP,   C_ALWAYS,  S_IDLE};
        endcase
        return w;
    endfunction

    // Color wheel, returned as {red, green, blue}
    function automatic logic [23:0] wheel_rgb(input logic [7:0] h);
        logic [7:0] p;
        logic [7:0] up;
        logic [7:0] dn;
        if (h < 8'd85) begin
            p = h;
        end else if (h < 8'd170) begin
            p = h - 8'd85;
        end else begin
            p = h - 8'd170;
        end
        up = p + {p[6:0], 1'b0};
        dn = 8'd255 - up;
        if (h < 8'd85) begin
            return {dn, up, 8'd0};
        end else if (h < 8'd170) begin
            return {8'd0, dn, up};
        end else begin
            return {up, 8'd0, dn};
        end
    endfunction

endpackage

@@ src/led_fx_seq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module led_fx_seq
    import led_fx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_op     o_op
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_take;

    assign w_word = ucode(r_pc);
    assign o_op   = w_word.op;

    // Evaluate the jump condition of the current step
    always_comb begin
        case (w_word.cond)
            C_NEXT:    w_take = 1'b0;
            C_ALWAYS:  w_take = 1'b1;
            C_NOTICK:  w_take = !i_status.tick;
            C_NOFRAME: w_take = i_status.no_frame;
            C_QGE:     w_take = i_status.q_ge;
            C_BUSY:    w_take = i_status.out_busy;
            C_FEND:    w_take = i_status.frame_end;
            C_INPIX:   w_take = i_status.in_pixel;
            default:   w_take = 1'b0;
        endcase
        n_pc = w_take ? w_word.target : r_pc + t_pc'(1);
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

@@ src/led_fx_dp.sv @@
// Datapath: pixel store, effect state, color generation, scaling and output register.
`timescale 1ns / 1ps

module led_fx_dp
    import led_fx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_op       i_op,
    output t_status   o_status,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);

    localparam logic [1:0] FUNC_SET   = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_FLASH = 2'd2;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_HUE    = 2'd1;
    localparam logic [1:0] REG_BRIGHT = 2'd2;

    localparam logic [1:0] MODE_HOLD    = 2'd0;
    localparam logic [1:0] MODE_BREATHE = 2'd1;
    localparam logic [1:0] MODE_RAINBOW = 2'd2;

    localparam logic [2:0] K_FLASH   = 3'd0;
    localparam logic [2:0] K_BREATHE = 3'd1;
    localparam logic [2:0] K_RAINBOW = 3'd2;
    localparam logic [2:0] K_CHASE   = 3'd3;
    localparam logic [2:0] K_BASE    = 3'd4;

    // Control state
    logic [7:0]  r_tick;
    logic [7:0]  r_flash_rem;
    logic [23:0] r_flash_col;
    logic        r_refresh;
    logic [1:0]  r_mode;
    logic [7:0]  r_hue;
    logic [7:0]  r_bright;
    logic [23:0] r_base [NUM_PIXELS];
    logic        r_out_valid;

    // Frame working registers
    logic [2:0]       r_kind;
    logic [7:0]       r_level;
    logic [7:0]       r_scale;
    logic [4:0]       r_q;
    logic [7:0]       r_h;
    logic [PIX_W-1:0] r_pix;
    logic [1:0]       r_comp;
    logic [5:0]       r_pos;
    logic [23:0]      r_col;
    logic [15:0]      r_prod;
    t_out_item        r_out;

    logic        w_accept;
    logic        w_out_busy;
    logic        w_flash_on;
    logic [7:0]  w_tick_next;
    logic [5:0]  w_tri;
    logic [7:0]  w_breathe;
    logic [23:0] w_wheel_hue;
    logic [23:0] w_wheel_h;
    logic [23:0] w_grb_hue;
    logic [23:0] w_grb_h;
    logic [7:0]  w_byte;
    logic [15:0] w_bl;

    assign o_in_ready  = (i_op == OP_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_busy  = r_out_valid && !i_out_ready;
    assign w_flash_on  = (r_flash_rem != 8'd0);
    assign w_tick_next = r_tick + 8'd1;

    assign o_status.tick      = w_accept && (i_in.func == FUNC_TICK);
    assign o_status.no_frame  = !w_flash_on && (r_mode == MODE_HOLD) && !r_refresh;
    assign o_status.q_ge      = (r_q >= 5'(NUM_PIXELS));
    assign o_status.out_busy  = w_out_busy;
    assign o_status.frame_end = (r_pos == 6'(FRAME_BYTES));
    assign o_status.in_pixel  = (r_comp != 2'd0);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Triangle level for breathe, floored at twelve
    always_comb begin
        w_tri     = w_tick_next[6] ? ~w_tick_next[5:0] : w_tick_next[5:0];
        w_breathe = {w_tri, 2'b00};
        if (w_breathe < 8'd12) begin
            w_breathe = 8'd12;
        end
    end

    // Wheel colors, reordered to G,R,B
    assign w_wheel_hue = wheel_rgb(r_hue);
    assign w_wheel_h   = wheel_rgb(r_h);
    assign w_grb_hue   = {w_wheel_hue[15:8], w_wheel_hue[23:16], w_wheel_hue[7:0]};
    assign w_grb_h     = {w_wheel_h[15:8], w_wheel_h[23:16], w_wheel_h[7:0]};

    // Pick the current byte of the pixel color
    always_comb begin
        case (r_comp)
            2'd0:    w_byte = r_col[23:16];
            2'd1:    w_byte = r_col[15:8];
            default: w_byte = r_col[7:0];
        endcase
    end

    assign w_bl = r_bright * r_level;

    // Control state: commands, configuration, countdown, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= 8'd0;
            r_flash_rem <= 8'd0;
            r_flash_col <= 24'd0;
            r_refresh   <= 1'b1;
            r_mode      <= MODE_HOLD;
            r_hue       <= 8'd0;
            r_bright    <= 8'd255;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PIXELS; i++) begin
                r_base[i] <= 24'd0;
            end
        end else begin
            // Take a configuration write
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE: begin
                        r_mode    <= i_cfg_wdata[1:0];
                        r_refresh <= 1'b1;
                    end
                    REG_HUE: begin
                        r_hue     <= i_cfg_wdata;
                        r_refresh <= 1'b1;
                    end
                    REG_BRIGHT: r_bright <= i_cfg_wdata;
                    default: ;
                endcase
            end
            // Store a pixel or arm a flash
            if (w_accept && (i_in.func == FUNC_SET) &&
                (i_in.pixel_index < 8'(NUM_PIXELS))) begin
                r_base[i_in.pixel_index[PIX_W-1:0]] <=
                    {i_in.green, i_in.red, i_in.blue};
                r_refresh <= 1'b1;
            end
            if (w_accept && (i_in.func == FUNC_FLASH)) begin
                r_flash_col <= {i_in.green, i_in.red, i_in.blue};
                r_flash_rem <= i_in.flash_length;
            end
            // Advance the frame counter and flash countdown
            if (i_op == OP_START) begin
                r_tick <= w_tick_next;
                if (w_flash_on) begin
                    r_flash_rem <= r_flash_rem - 8'd1;
                    r_refresh   <= 1'b1;
                end else if (r_mode == MODE_HOLD) begin
                    r_refresh <= 1'b0;
                end
            end
            // Hold the output until taken
            if ((i_op == OP_EMIT) && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame working registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                if (w_flash_on) begin
                    r_kind  <= K_FLASH;
                    r_level <= 8'd255;
                end else begin
                    case (r_mode)
                        MODE_HOLD: begin
                            r_kind  <= K_BASE;
                            r_level <= 8'd255;
                        end
                        MODE_BREATHE: begin
                            r_kind  <= K_BREATHE;
                            r_level <= w_breathe;
                        end
                        MODE_RAINBOW: begin
                            r_kind  <= K_RAINBOW;
                            r_level <= 8'd255;
                        end
                        default: begin
                            r_kind  <= K_CHASE;
                            r_level <= 8'd255;
                        end
                    endcase
                end
            end
            OP_SCALE: begin
                r_scale <= w_bl[15:8];
                r_q     <= r_tick[7:3];
                r_h     <= r_tick + {r_tick[6:0], 1'b0};
                r_pix   <= '0;
                r_comp  <= 2'd0;
                r_pos   <= 6'd0;
            end
            OP_MOD: begin
                if (o_status.q_ge) begin
                    r_q <= r_q - 5'(NUM_PIXELS);
                end
            end
            OP_COLOR: begin
                case (r_kind)
                    K_FLASH:   r_col <= r_flash_col;
                    K_BREATHE: r_col <= w_grb_hue;
                    K_RAINBOW: r_col <= w_grb_h;
                    K_CHASE:   r_col <= (5'(r_pix) == r_q) ? w_grb_hue : 24'd0;
                    default:   r_col <= r_base[r_pix];
                endcase
            end
            OP_MUL: begin
                r_prod <= w_byte * r_scale;
            end
            OP_EMIT: begin
                if (!w_out_busy) begin
                    r_out.pixel_byte    <= r_prod[15:8];
                    r_out.byte_position <= r_pos;
                    r_out.last          <= (r_pos == 6'(FRAME_BYTES - 1));
                    r_pos               <= r_pos + 6'd1;
                    if (r_comp == 2'd2) begin
                        r_comp <= 2'd0;
                        r_pix  <= r_pix + PIX_W'(1);
                        r_h    <= r_h + 8'd60;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/led_effects_frame_engine_top.sv @@
// Top level of the LED strip frame engine: sequencer plus datapath.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in) carries commands:
//   set pixel color, frame tick, start flash. A transaction is taken when
//   both are high at a rising edge. o_in_ready is high only while the
//   sequencer sits at its idle step; set-pixel and flash commands finish in
//   the cycle they are accepted.
//   A frame tick runs the control program: one step to advance the tick, one
//   to form the scale, 1 + (tick/8)/NUM_PIXELS steps (1 to 11) for the chase
//   position loop, then per pixel one color step, four steps per byte
//   (multiply, emit, two branch steps) and one step to the next pixel, so 14
//   steps a pixel and 12 for the last. The first byte becomes valid after
//   the emit step of the first pixel, and o_in_ready stays low until the
//   program returns to idle, so a new tick waits until the frame is done.
//   A hold frame with nothing new drops o_in_ready for one cycle and emits
//   nothing. Output channel (o_out_valid / i_out_ready, payload o_out)
//   delivers one byte per transaction in G,R,B order, last flagged on the
//   final byte; a stalled byte holds the program at its emit step.
//   Configuration writes take effect at once; the user must make them only
//   while idle; the block itself leaves this to the user. Synchronous reset
//   clears pixels, counters and flash, sets full brightness, marks hold.
`timescale 1ns / 1ps

module led_effects_frame_engine_top
    import led_fx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_wdata
);

    t_op     w_op;
    t_status w_status;

    // Control program
    led_fx_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_op     (w_op)
    );

    // Datapath
    led_fx_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the LED strip frame engine with a built-in frame predictor.
`timescale 1ns / 1ps

module tb_top;
    import led_fx_pkg::*;

    typedef enum logic [1:0] {
        FN_SET_PIXEL = 2'd0,
        FN_TICK      = 2'd1,
        FN_FLASH     = 2'd2,
        FN_SPARE     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_HOLD    = 2'd0,
        MODE_BREATHE = 2'd1,
        MODE_RAINBOW = 2'd2,
        MODE_CHASE   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_HUE    = 2'd1,
        REG_BRIGHT = 2'd2,
        REG_SPARE  = 2'd3
    } t_reg;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 64;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 40;
    localparam int FULL_LEVEL    = 255;
    localparam int BREATHE_FLOOR = 12;

    // Frame predictor: mirrors engine state and queues the bytes each command owes
    class frame_scoreboard;
        logic [7:0]  base [FRAME_BYTES];
        logic [7:0]  work [FRAME_BYTES];
        logic [7:0]  tick;
        logic [7:0]  flash_left;
        logic [23:0] flash_rgb;
        logic        refresh;
        t_mode       mode;
        logic [7:0]  hue;
        logic [7:0]  bright;
        t_out_item   frame_q[$];
        int          errors;

        function new();
            foreach (base[k]) base[k] = 8'd0;
            tick       = 8'd0;
            flash_left = 8'd0;
            flash_rgb  = 24'd0;
            refresh    = 1'b1;
            mode       = MODE_HOLD;
            hue        = 8'd0;
            bright     = 8'd255;
            errors     = 0;
        endfunction

        // Color wheel position to {red, green, blue}
        function logic [23:0] hue_to_rgb(int h);
            int p;
            logic [7:0] up;
            logic [7:0] dn;
            if (h < 85) begin
                p = h;
            end else if (h < 170) begin
                p = h - 85;
            end else begin
                p = h - 170;
            end
            up = 8'(3 * p);
            dn = 8'(255 - 3 * p);
            if (h < 85) begin
                return {dn, up, 8'd0};
            end else if (h < 170) begin
                return {8'd0, dn, up};
            end
            return {up, 8'd0, dn};
        endfunction

        // Store one pixel in the scratch frame, G,R,B order
        function void paint(int p, logic [23:0] rgb);
            work[3 * p]     = rgb[15:8];
            work[3 * p + 1] = rgb[23:16];
            work[3 * p + 2] = rgb[7:0];
        endfunction

        // Scale a frame and queue its bytes
        function void queue_frame(logic [7:0] src [FRAME_BYTES], int level);
            int s;
            t_out_item o;
            s = (bright * level) >> 8;
            for (int k = 0; k < FRAME_BYTES; k++) begin
                o.pixel_byte    = 8'((src[k] * s) >> 8);
                o.byte_position = k[5:0];
                o.last          = (k == FRAME_BYTES - 1);
                frame_q.push_back(o);
            end
        endfunction

        function void write_reg(t_reg idx, logic [7:0] val);
            case (idx)
                REG_MODE: begin
                    mode    = t_mode'(val[1:0]);
                    refresh = 1'b1;
                end
                REG_HUE: begin
                    hue     = val;
                    refresh = 1'b1;
                end
                REG_BRIGHT: begin
                    bright = val;
                end
                default: begin
                end
            endcase
        endfunction

        function void note_input(t_in_item it);
            int t;
            int level;
            int lit;
            logic [23:0] rgb;
            case (t_func'(it.func))
                FN_SET_PIXEL: begin
                    if (it.pixel_index < NUM_PIXELS) begin
                        base[3 * it.pixel_index]     = it.green;
                        base[3 * it.pixel_index + 1] = it.red;
                        base[3 * it.pixel_index + 2] = it.blue;
                        refresh = 1'b1;
                    end
                end
                FN_FLASH: begin
                    flash_rgb  = {it.red, it.green, it.blue};
                    flash_left = it.flash_length;
                end
                FN_TICK: begin
                    tick = tick + 8'd1;
                    if (flash_left != 8'd0) begin
                        // flash overrides any effect
                        flash_left = flash_left - 8'd1;
                        for (int p = 0; p < NUM_PIXELS; p++) paint(p, flash_rgb);
                        refresh = 1'b1;
                        queue_frame(work, FULL_LEVEL);
                    end else begin
                        case (mode)
                            MODE_BREATHE: begin
                                t = tick & 127;
                                level = ((t < 64) ? t : 127 - t) * 4;
                                if (level < BREATHE_FLOOR) level = BREATHE_FLOOR;
                                rgb = hue_to_rgb(hue);
                                for (int p = 0; p < NUM_PIXELS; p++) paint(p, rgb);
                                queue_frame(work, level);
                            end
                            MODE_RAINBOW: begin
                                for (int p = 0; p < NUM_PIXELS; p++) begin
                                    paint(p, hue_to_rgb((tick * 3 + p * 60) % 256));
                                end
                                queue_frame(work, FULL_LEVEL);
                            end
                            MODE_CHASE: begin
                                lit = (tick >> 3) % NUM_PIXELS;
                                rgb = hue_to_rgb(hue);
                                for (int p = 0; p < NUM_PIXELS; p++) begin
                                    paint(p, (p == lit) ? rgb : 24'd0);
                                end
                                queue_frame(work, FULL_LEVEL);
                            end
                            default: begin
                                // hold: re-emit base colors only when marked
                                if (refresh) begin
                                    refresh = 1'b0;
                                    queue_frame(base, FULL_LEVEL);
                                end
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_byte(t_out_item got);
            t_out_item want;
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected byte, expected none, got %h", $time, got);
                errors++;
            end else begin
                want = frame_q.pop_front();
                if (got.pixel_byte !== want.pixel_byte) begin
                    $display("%0t: pixel_byte expected %h got %h",
                             $time, want.pixel_byte, got.pixel_byte);
                    errors++;
                end
                if (got.byte_position !== want.byte_position) begin
                    $display("%0t: byte_position expected %0d got %0d",
                             $time, want.byte_position, got.byte_position);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %b got %b", $time, want.last, got.last);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return frame_q.size();
        endfunction
    endclass

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_wdata = 8'd0;
    bit         quiet     = 1'b0;
    int         cycles    = 0;

    frame_scoreboard frames = new();

    led_effects_frame_engine_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic t_in_item mk(t_func f, logic [7:0] idx, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b, logic [7:0] len);
        t_in_item it;
        it.func         = f;
        it.pixel_index  = idx;
        it.red          = r;
        it.green        = g;
        it.blue         = b;
        it.flash_length = len;
        return it;
    endfunction

    // Random byte, biased toward the extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int pick;
        it = mk(FN_TICK, 8'($urandom_range(0, 255)), rand_byte(), rand_byte(), rand_byte(),
                8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.func = FN_TICK;
        end else if (pick < 80) begin
            it.func = FN_SET_PIXEL;
            if ($urandom_range(0, 9) != 0) begin
                it.pixel_index = 8'($urandom_range(0, NUM_PIXELS - 1));
            end else begin
                it.pixel_index = 8'($urandom_range(NUM_PIXELS, 255));
            end
        end else if (pick < 94) begin
            it.func = FN_FLASH;
            if ($urandom_range(0, 19) != 0) it.flash_length = 8'($urandom_range(0, 4));
        end else begin
            it.func = FN_SPARE;
        end
        return it;
    endfunction

    // Offer one command after a random gap; hold it until taken
    task automatic send_cmd(t_in_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!in_ready);
        frames.note_input(it);
    endtask

    task automatic cfg_write(t_reg idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        frames.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain owed bytes, then let a silent hold frame finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (frames.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_directed();
        // hold frame owed from reset, then nothing new
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // extreme colors, last pixel, and indexes past the strip
        send_cmd(mk(FN_SET_PIXEL, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(mk(FN_SET_PIXEL, 8'(NUM_PIXELS - 1), 8'hAA, 8'h55, 8'h0F, 8'h00));
        send_cmd(mk(FN_SET_PIXEL, 8'(NUM_PIXELS), 8'h11, 8'h22, 8'h33, 8'h00));
        send_cmd(mk(FN_SET_PIXEL, 8'hFF, 8'h44, 8'h55, 8'h66, 8'h00));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // unused function code changes nothing
        send_cmd(mk(FN_SPARE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // two-frame flash, then hold re-emits
        send_cmd(mk(FN_FLASH, 8'd0, 8'h12, 8'hFF, 8'h80, 8'd2));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        // zero length cancels a long flash
        send_cmd(mk(FN_FLASH, 8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_cmd(mk(FN_FLASH, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(mk(FN_SET_PIXEL, 8'd1, 8'h01, 8'h80, 8'hFE, 8'h00));

        // breathe at zero brightness
        wait_idle();
        cfg_write(REG_BRIGHT, 8'h00);
        cfg_write(REG_HUE, 8'h00);
        cfg_write(REG_MODE, {6'h3F, MODE_BREATHE});
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        // rainbow at full brightness; unused register index is ignored
        wait_idle();
        cfg_write(REG_BRIGHT, 8'hFF);
        cfg_write(REG_HUE, 8'hFF);
        cfg_write(REG_MODE, {6'h00, MODE_RAINBOW});
        cfg_write(REG_SPARE, 8'hFF);
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        wait_idle();
        cfg_write(REG_MODE, {6'h15, MODE_CHASE});
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

        // mode write marks hold for output
        wait_idle();
        cfg_write(REG_MODE, {6'h2A, MODE_HOLD});
        send_cmd(mk(FN_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    endtask

    // Result side: random stalls, check every byte taken
    initial begin
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            frames.check_byte(out_item);
        end
    end

    // Command side: directed part, then random phases under new settings
    initial begin
        t_mode mode;
        logic [5:0] junk;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            // force breathe across the tick wrap so the level floor is reached
            if (frames.tick >= 8'd100 && frames.tick <= 8'd127) begin
                mode = MODE_BREATHE;
            end else begin
                mode = t_mode'($urandom_range(0, 3));
            end
            junk = 6'($urandom_range(0, 63));
            cfg_write(REG_MODE, {junk, mode});
            cfg_write(REG_HUE, rand_byte());
            cfg_write(REG_BRIGHT, rand_byte());
            if ($urandom_range(0, 2) == 0) cfg_write(REG_SPARE, 8'($urandom_range(0, 255)));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) send_cmd(rand_item());
        end
        wait_idle();
        if (frames.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
